@@ rtl/core/rgb_to_hsv_converter_macros.svh @@
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define RTH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RTH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rth_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rth_pkg;

    // fixed point format of the results
    localparam int HUE_FRAC_BITS = 4;
    localparam int SAT_BITS      = 8;
    localparam int CHAN_W        = 8;
    localparam int CHAN_MAX      = (1 << CHAN_W) - 1;

    localparam int HUE_W    = 9 + HUE_FRAC_BITS;
    localparam int HUE_STEP = 60 << HUE_FRAC_BITS;
    localparam int HUE_FULL = 360 << HUE_FRAC_BITS;
    localparam int SAT_MAX  = (1 << SAT_BITS) - 1;

    // sextant numerator: offset * delta + difference, at most 7 * delta
    localparam int NUM_W = $clog2(7 * CHAN_MAX + 1);

    // divider operand widths
    localparam int HUE_DIVD_W = $clog2(HUE_STEP * 7 * CHAN_MAX + 1);
    localparam int HUE_QW     = $clog2(HUE_STEP * 7 + 1);
    localparam int HUE_CW     = HUE_DIVD_W + CHAN_W;
    localparam int SAT_DIVD_W = $clog2(SAT_MAX * CHAN_MAX + 1);
    localparam int SAT_QW     = SAT_BITS;
    localparam int SAT_CW     = SAT_DIVD_W + CHAN_W;

    // quotient bits resolved per divider stage
    localparam int QBITS_PER_STAGE = 2;
    localparam int DIV_QW_MAX      = (HUE_QW > SAT_QW) ? HUE_QW : SAT_QW;
    localparam int DIV_STAGES      = (DIV_QW_MAX + QBITS_PER_STAGE - 1) / QBITS_PER_STAGE;

    // stream widths
    localparam int S_TDATA_W  = 32;
    localparam int M_FIELDS_W = HUE_W + SAT_BITS + CHAN_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // pipeline control handed to the divider
    typedef struct packed {
        logic adv;
        logic vld;
    } rth_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/rth_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rth_divider (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rth_pkg::rth_ctrl_t            ctrl,
    input  wire logic [rth_pkg::HUE_DIVD_W-1:0] hue_dvd,
    input  wire logic [rth_pkg::CHAN_W-1:0]     hue_dvs,
    input  wire logic [rth_pkg::SAT_DIVD_W-1:0] sat_dvd,
    input  wire logic [rth_pkg::CHAN_W-1:0]     sat_dvs,
    input  wire logic [rth_pkg::CHAN_W-1:0]     val_in,
    output logic                               out_vld,
    output logic [rth_pkg::HUE_QW-1:0]         hue_q,
    output logic [rth_pkg::SAT_QW-1:0]         sat_q,
    output logic [rth_pkg::CHAN_W-1:0]         val_out
);
    import rth_pkg::*;

    // per-stage registers of the restoring divider
    logic [DIV_STAGES-1:0]   vld_reg;
    logic [HUE_DIVD_W-1:0]   hrem_reg [DIV_STAGES];
    logic [HUE_QW-1:0]       hq_reg   [DIV_STAGES];
    logic [CHAN_W-1:0]       hdvs_reg [DIV_STAGES];
    logic [SAT_DIVD_W-1:0]   srem_reg [DIV_STAGES];
    logic [SAT_QW-1:0]       sq_reg   [DIV_STAGES];
    logic [CHAN_W-1:0]       sdvs_reg [DIV_STAGES];
    logic [CHAN_W-1:0]       val_reg  [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic                  vld_in;
        logic [HUE_DIVD_W-1:0] hrem_in;
        logic [HUE_QW-1:0]     hq_in;
        logic [CHAN_W-1:0]     hdvs_in;
        logic [SAT_DIVD_W-1:0] srem_in;
        logic [SAT_QW-1:0]     sq_in;
        logic [CHAN_W-1:0]     sdvs_in;
        logic [CHAN_W-1:0]     val_s_in;
        logic [HUE_DIVD_W-1:0] hrem_next;
        logic [HUE_QW-1:0]     hq_next;
        logic [SAT_DIVD_W-1:0] srem_next;
        logic [SAT_QW-1:0]     sq_next;

        // stage input: module ports or previous stage
        if (s == 0) begin : g_first
            assign vld_in   = ctrl.vld;
            assign hrem_in  = hue_dvd;
            assign hq_in    = '0;
            assign hdvs_in  = hue_dvs;
            assign srem_in  = sat_dvd;
            assign sq_in    = '0;
            assign sdvs_in  = sat_dvs;
            assign val_s_in = val_in;
        end else begin : g_rest
            assign vld_in   = vld_reg[s-1];
            assign hrem_in  = hrem_reg[s-1];
            assign hq_in    = hq_reg[s-1];
            assign hdvs_in  = hdvs_reg[s-1];
            assign srem_in  = srem_reg[s-1];
            assign sq_in    = sq_reg[s-1];
            assign sdvs_in  = sdvs_reg[s-1];
            assign val_s_in = val_reg[s-1];
        end

        // compare and subtract for this stage's quotient bits
        always_comb begin
            logic [HUE_CW-1:0] htrial;
            logic [SAT_CW-1:0] strial;
            int                hidx;
            int                sidx;
            hrem_next = hrem_in;
            hq_next   = hq_in;
            srem_next = srem_in;
            sq_next   = sq_in;
            htrial    = '0;
            strial    = '0;
            for (int j = 0; j < QBITS_PER_STAGE; j++) begin
                hidx = HUE_QW - 1 - (s * QBITS_PER_STAGE + j);
                sidx = SAT_QW - 1 - (s * QBITS_PER_STAGE + j);
                if (hidx >= 0) begin
                    htrial = HUE_CW'(hdvs_in) << hidx;
                    if (HUE_CW'(hrem_next) >= htrial) begin
                        hrem_next = hrem_next - HUE_DIVD_W'(htrial);
                        hq_next   = hq_next | (HUE_QW'(1) << hidx);
                    end
                end
                if (sidx >= 0) begin
                    strial = SAT_CW'(sdvs_in) << sidx;
                    if (SAT_CW'(srem_next) >= strial) begin
                        srem_next = srem_next - SAT_DIVD_W'(strial);
                        sq_next   = sq_next | (SAT_QW'(1) << sidx);
                    end
                end
            end
        end

        // valid bit
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (ctrl.adv) begin
                vld_reg[s] <= vld_in;
            end
        end

        // payload
        always_ff @(posedge aclk) begin
            if (ctrl.adv) begin
                hrem_reg[s] <= hrem_next;
                hq_reg[s]   <= hq_next;
                hdvs_reg[s] <= hdvs_in;
                srem_reg[s] <= srem_next;
                sq_reg[s]   <= sq_next;
                sdvs_reg[s] <= sdvs_in;
                val_reg[s]  <= val_s_in;
            end
        end
    end

    assign out_vld = vld_reg[DIV_STAGES-1];
    assign hue_q   = hq_reg[DIV_STAGES-1];
    assign sat_q   = sq_reg[DIV_STAGES-1];
    assign val_out = val_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/core/rgb_to_hsv_converter.sv @@
// channel   dir  handshake            payload
// s_axis    in   s_tvalid / s_tready  s_tdata: color word (alpha, red, green, blue)
// m_axis    out  m_tvalid / m_tready  m_tdata: hue, saturation, value
//
// one pixel per clock sustained while the output is not stalled; 11 register stages:
// 3 front stages (max/min, sextant numerator, scaling), 7 divider stages
// resolving 2 quotient bits each, 1 output stage with the hue wrap.
// reset (aresetn low, synchronous) clears only the valid bits.
// a stalled output freezes the whole pipeline; s_tready is low while the output
// register holds a transaction that is not being taken.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [31:0] color_word
    input  wire logic [rth_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [12:0] hue_sixteenths, [20:13] saturation_level, [28:21] value_level, rest zero
    output logic [rth_pkg::M_TDATA_W-1:0]      m_tdata
);
    import rth_pkg::*;

    typedef enum logic [1:0] {
        SEXT_RED,
        SEXT_GREEN,
        SEXT_BLUE
    } sext_t;

    logic pipe_adv;

    // stage a: channel extremes and sextant
    logic              a_vld_reg;
    logic [CHAN_W-1:0] a_r_reg, a_g_reg, a_b_reg, a_hi_reg, a_lo_reg;
    sext_t             a_sext_reg;
    logic [CHAN_W-1:0] a_r_next, a_g_next, a_b_next, a_hi_next, a_lo_next;
    sext_t             a_sext_next;

    // stage b: delta and non-negative sextant numerator
    logic              b_vld_reg;
    logic [CHAN_W-1:0] b_delta_reg, b_hi_reg;
    logic [NUM_W-1:0]  b_num_reg;
    logic [CHAN_W-1:0] b_delta_next;
    logic [NUM_W-1:0]  b_num_next;

    // stage c: divider operands
    logic                  c_vld_reg;
    logic [HUE_DIVD_W-1:0] c_hue_dvd_reg;
    logic [CHAN_W-1:0]     c_hue_dvs_reg;
    logic [SAT_DIVD_W-1:0] c_sat_dvd_reg;
    logic [CHAN_W-1:0]     c_sat_dvs_reg;
    logic [CHAN_W-1:0]     c_hi_reg;

    // divider outputs
    logic              d_vld;
    logic [HUE_QW-1:0] d_hue_q;
    logic [SAT_QW-1:0] d_sat_q;
    logic [CHAN_W-1:0] d_val;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [HUE_W-1:0]     hue_wrapped;

    // whole pipeline moves when the output register is free or being emptied
    assign pipe_adv = !m_tvalid_reg || m_tready;
    assign s_tready = pipe_adv;

    // max, min and sextant, red first, then green, then blue
    always_comb begin
        a_r_next  = s_tdata[23:16];
        a_g_next  = s_tdata[15:8];
        a_b_next  = s_tdata[7:0];
        a_hi_next = a_r_next;
        a_lo_next = a_r_next;
        if (a_g_next > a_hi_next) begin
            a_hi_next = a_g_next;
        end
        if (a_b_next > a_hi_next) begin
            a_hi_next = a_b_next;
        end
        if (a_g_next < a_lo_next) begin
            a_lo_next = a_g_next;
        end
        if (a_b_next < a_lo_next) begin
            a_lo_next = a_b_next;
        end
        if (a_hi_next == a_r_next) begin
            a_sext_next = SEXT_RED;
        end else if (a_hi_next == a_g_next) begin
            a_sext_next = SEXT_GREEN;
        end else begin
            a_sext_next = SEXT_BLUE;
        end
    end

    // numerator offset * delta plus the signed difference, always non-negative
    always_comb begin
        b_delta_next = a_hi_reg - a_lo_reg;
        unique case (a_sext_reg)
            SEXT_RED: begin
                b_num_next = NUM_W'(6) * NUM_W'(b_delta_next)
                           + NUM_W'(a_g_reg) - NUM_W'(a_b_reg);
            end
            SEXT_GREEN: begin
                b_num_next = NUM_W'(2) * NUM_W'(b_delta_next)
                           + NUM_W'(a_b_reg) - NUM_W'(a_r_reg);
            end
            SEXT_BLUE: begin
                b_num_next = NUM_W'(4) * NUM_W'(b_delta_next)
                           + NUM_W'(a_r_reg) - NUM_W'(a_g_reg);
            end
            default: begin
                b_num_next = '0;
            end
        endcase
    end

    // front stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else if (pipe_adv) begin
            a_vld_reg <= s_tvalid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    // front stage payload; a zero divisor is replaced by one over a zero dividend
    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            a_r_reg    <= a_r_next;
            a_g_reg    <= a_g_next;
            a_b_reg    <= a_b_next;
            a_hi_reg   <= a_hi_next;
            a_lo_reg   <= a_lo_next;
            a_sext_reg <= a_sext_next;

            b_delta_reg <= b_delta_next;
            b_num_reg   <= b_num_next;
            b_hi_reg    <= a_hi_reg;

            c_hue_dvd_reg <= (b_delta_reg == '0) ? '0
                           : HUE_DIVD_W'(b_num_reg) * HUE_DIVD_W'(HUE_STEP);
            c_hue_dvs_reg <= (b_delta_reg == '0) ? CHAN_W'(1) : b_delta_reg;
            c_sat_dvd_reg <= SAT_DIVD_W'(b_delta_reg) * SAT_DIVD_W'(SAT_MAX);
            c_sat_dvs_reg <= (b_hi_reg == '0) ? CHAN_W'(1) : b_hi_reg;
            c_hi_reg      <= b_hi_reg;
        end
    end

    rth_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    ('{adv: pipe_adv, vld: c_vld_reg}),
        .hue_dvd (c_hue_dvd_reg),
        .hue_dvs (c_hue_dvs_reg),
        .sat_dvd (c_sat_dvd_reg),
        .sat_dvs (c_sat_dvs_reg),
        .val_in  (c_hi_reg),
        .out_vld (d_vld),
        .hue_q   (d_hue_q),
        .sat_q   (d_sat_q),
        .val_out (d_val)
    );

    // hue quotient stays below two turns, so one subtract wraps it
    assign hue_wrapped = (d_hue_q >= HUE_QW'(HUE_FULL)) ? HUE_W'(d_hue_q - HUE_QW'(HUE_FULL))
                                                      : HUE_W'(d_hue_q);

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pipe_adv) begin
            m_tvalid_reg <= d_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            m_tdata_reg <= M_TDATA_W'({d_val, d_sat_q, hue_wrapped});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `include "rgb_to_hsv_converter_macros.svh"

    `RTH_ASSERT_IMPL(a_hue_range, m_tvalid, m_tdata[HUE_W-1:0] < HUE_W'(HUE_FULL), "hue out of range")
    `RTH_ASSERT_IMPL(a_black, m_tvalid && (m_tdata[M_FIELDS_W-1:HUE_W+SAT_BITS] == '0), m_tdata[HUE_W+SAT_BITS-1:0] == '0, "black pixel with hue or saturation")
    `RTH_ASSERT_NEXT(a_stall_hold, !pipe_adv, $stable(a_vld_reg) && $stable(c_vld_reg), "pipeline moved during stall")

endmodule

`default_nettype wire

@@ test/tb_rgb_to_hsv_converter.sv @@
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter;

    import rth_pkg::*;

    localparam int LATENCY     = 11;
    localparam int RANDOM_PIXS = 900;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED  = 23;

    // one converted pixel as it leaves the block
    typedef struct packed {
        logic [HUE_W-1:0]    hue;
        logic [SAT_BITS-1:0] sat;
        logic [CHAN_W-1:0]   val;
    } hsv_t;

    // directed row: a typed-in result is used where fixed is set
    typedef struct packed {
        logic [S_TDATA_W-1:0] word;
        bit                   fixed;
        hsv_t                 want;
    } pixel_case_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    hsv_t        expected_hsv [$];
    int unsigned mismatches   = 0;
    int unsigned pixels_sent  = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count  = 0;
    logic        no_gaps      = 1'b0;
    int unsigned stall_left   = 0;
    int unsigned rdy_gap;

    pixel_case_t directed_cases [0:N_DIRECTED-1] = '{
        // black, and alpha alone
        '{32'h0000_0000, 1'b1, '{13'd0,    8'd0,   8'd0}},
        '{32'hFF00_0000, 1'b1, '{13'd0,    8'd0,   8'd0}},
        // white and mid gray: no hue, no saturation
        '{32'hFFFF_FFFF, 1'b1, '{13'd0,    8'd0,   8'd255}},
        '{32'h0080_8080, 1'b1, '{13'd0,    8'd0,   8'd128}},
        // primaries; pure red wraps a full turn back to zero
        '{32'h00FF_0000, 1'b1, '{13'd0,    8'd255, 8'd255}},
        '{32'h0000_FF00, 1'b1, '{13'd1920, 8'd255, 8'd255}},
        '{32'h0000_00FF, 1'b1, '{13'd3840, 8'd255, 8'd255}},
        // secondaries: ties for the maximum go red, then green
        '{32'h00FF_FF00, 1'b1, '{13'd960,  8'd255, 8'd255}},
        '{32'h0000_FFFF, 1'b1, '{13'd2880, 8'd255, 8'd255}},
        '{32'h00FF_00FF, 1'b1, '{13'd4800, 8'd255, 8'd255}},
        // smallest non-zero channels
        '{32'h0001_0000, 1'b1, '{13'd0,    8'd255, 8'd1}},
        '{32'h0000_0001, 1'b1, '{13'd3840, 8'd255, 8'd1}},
        // alpha must not change anything
        '{32'h7F00_FF00, 1'b1, '{13'd1920, 8'd255, 8'd255}},
        // arbitrary hues in every sextant
        '{32'h00FF_8040, 1'b0, '0},
        '{32'h00FE_0102, 1'b0, '0},
        '{32'h0040_FF80, 1'b0, '0},
        '{32'h0080_40FF, 1'b0, '0},
        '{32'h0001_0203, 1'b0, '0},
        '{32'h00FF_FEFF, 1'b0, '0},
        '{32'h00FE_FFFF, 1'b0, '0},
        '{32'h00FF_FFFE, 1'b0, '0},
        '{32'hA5C3_E17F, 1'b0, '0},
        '{32'h5A3C_1E80, 1'b0, '0}
    };

    rgb_to_hsv_converter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // hue in sixteenths of a degree, exact integer sextant formula
    function automatic hsv_t convert_pixel(input logic [S_TDATA_W-1:0] word);
        int unsigned red;
        int unsigned grn;
        int unsigned blu;
        int unsigned hi;
        int unsigned lo;
        int unsigned delta;
        int unsigned num;
        hsv_t        res;
        red = word[23:16];
        grn = word[15:8];
        blu = word[7:0];
        hi  = red;
        lo  = red;
        if (grn > hi) hi = grn;
        if (blu > hi) hi = blu;
        if (grn < lo) lo = grn;
        if (blu < lo) lo = blu;
        delta = hi - lo;
        res   = '0;
        if (delta != 0) begin
            // offset keeps the numerator non-negative
            if (hi == red)
                num = 6 * delta + grn - blu;
            else if (hi == grn)
                num = 2 * delta + blu - red;
            else
                num = 4 * delta + red - grn;
            res.hue = HUE_W'(((HUE_STEP * num) / delta) % HUE_FULL);
        end
        if (hi != 0)
            res.sat = SAT_BITS'((SAT_MAX * delta) / hi);
        res.val = CHAN_W'(hi);
        return res;
    endfunction

    // mostly back to back, sometimes a short pause, rarely a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch in %s at result %0d: got %0d, expected %0d",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    // present one pixel and hold it until the transaction completes
    task automatic send_pixel(input logic [S_TDATA_W-1:0] word, input bit fixed,
                              input hsv_t want);
        int unsigned gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_hsv.push_back(fixed ? want : convert_pixel(word));
        pixels_sent++;
    endtask

    // random pixel biased towards grays, ties and small deltas
    function automatic logic [S_TDATA_W-1:0] random_pixel();
        logic [7:0] a;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        a  = 8'($urandom);
        c0 = 8'($urandom);
        c1 = 8'($urandom);
        c2 = 8'($urandom);
        case ($urandom_range(0, 9))
            0: c1 = c0;
            1: begin c1 = c0; c2 = c0; end
            2: c2 = c1;
            3: c2 = c0;
            4: begin c1 = c0 + 8'($urandom_range(0, 2)); c2 = c0 - 8'($urandom_range(0, 2)); end
            5: c0 = 8'($urandom_range(0, 1)) * 8'hFF;
            6: begin c1 = 8'h00; c2 = 8'($urandom_range(0, 3)); end
            default: ;
        endcase
        return {a, c0, c1, c2};
    endfunction

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn || no_gaps) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            rdy_gap    = pick_gap();
            stall_left <= rdy_gap;
            m_tready   <= (rdy_gap == 0);
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        hsv_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_hsv.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want = expected_hsv.pop_front();
                if (m_tdata[HUE_W-1:0] !== want.hue)
                    report_mismatch("hue", m_tdata[HUE_W-1:0], want.hue);
                if (m_tdata[HUE_W+SAT_BITS-1:HUE_W] !== want.sat)
                    report_mismatch("saturation", m_tdata[HUE_W+SAT_BITS-1:HUE_W], want.sat);
                if (m_tdata[M_FIELDS_W-1:HUE_W+SAT_BITS] !== want.val)
                    report_mismatch("value", m_tdata[M_FIELDS_W-1:HUE_W+SAT_BITS], want.val);
                if (m_tdata[M_TDATA_W-1:M_FIELDS_W] !== '0)
                    report_mismatch("padding", m_tdata[M_TDATA_W-1:M_FIELDS_W], 0);
                results_seen++;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_hsv.size());
            $display("status: fail");
            $finish;
        end
    end

    // stimulus
    initial begin
        int unsigned chunk;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_cases[i])
            send_pixel(directed_cases[i].word, directed_cases[i].fixed,
                       directed_cases[i].want);

        // random pixels in chunks, some chunks without any idling
        chunk = 0;
        for (int i = 0; i < RANDOM_PIXS; i++) begin
            if (chunk == 0) begin
                chunk   = $urandom_range(20, 120);
                no_gaps <= ($urandom_range(0, 3) == 0);
            end
            chunk--;
            send_pixel(random_pixel(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        no_gaps  <= 1'b0;

        // drain, then let any stray transaction show up
        while (expected_hsv.size() != 0) @(posedge aclk);
        repeat (3 * LATENCY) @(posedge aclk);

        $display("covered %0d directed and %0d random pixels, %0d results checked",
                 N_DIRECTED, pixels_sent - N_DIRECTED, results_seen);
        $display("grays, ties, primaries, alpha and random stalls on both sides, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/rth_pkg.sv
rtl/core/rth_divider.sv
rtl/core/rgb_to_hsv_converter.sv
test/tb_rgb_to_hsv_converter.sv
